[design/vmfir_pkg.sv]
// ----------------------------------------------------------------------------
// vmfir_pkg
// shared constants, register codes and types of the valid-mode fir filter
// ----------------------------------------------------------------------------
package vmfir_pkg;

    localparam int MAX_TAPS       = 16;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_WORDS     = 4;
    localparam int COEFS_PER_WORD = 4;
    localparam int NUM_COEFS      = COEF_WORDS * COEFS_PER_WORD;
    localparam int CFG_WIDTH      = 64;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int TAP_REG_WIDTH  = 5;
    localparam int OUT_WIDTH      = 36;
    localparam int CNT_WIDTH      = $clog2(MAX_TAPS + 1);
    localparam int COEF_IDX_WIDTH = $clog2(NUM_COEFS);
    localparam int PROD_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int GROUP_SIZE     = 4;
    localparam int NUM_GROUPS     = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PART_WIDTH     = PROD_WIDTH + $clog2(GROUP_SIZE);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_TAP_COUNT   = 3'd0,
        REG_COEF_WORD_0 = 3'd1,
        REG_COEF_WORD_1 = 3'd2,
        REG_COEF_WORD_2 = 3'd3,
        REG_COEF_WORD_3 = 3'd4
    } t_reg_idx;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;
    typedef t_sample [MAX_TAPS-1:0]         t_window;
    typedef t_coef   [MAX_TAPS-1:0]         t_coef_vec;

    // effective tap count and coefficients lined up with delay line entries
    typedef struct packed {
        logic [CNT_WIDTH-1:0] eff_taps;
        t_coef_vec            coef_sel;
    } t_cfg_view;

    // window stage handed from the delay line to the multiply stage
    typedef struct packed {
        logic    vld;
        t_window win;
    } t_win_stage;

endpackage

[design/vmfir_cfg.sv]
// ----------------------------------------------------------------------------
// vmfir_cfg
// configuration registers, tap count clamp and coefficient alignment
// ----------------------------------------------------------------------------
module vmfir_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [vmfir_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [vmfir_pkg::CFG_WIDTH-1:0]      i_cfg_wdata,
    output vmfir_pkg::t_cfg_view                 o_cfg_view
);
    import vmfir_pkg::*;

    logic [TAP_REG_WIDTH-1:0] r_tap_count;
    logic [CFG_WIDTH-1:0]     r_coef_word [COEF_WORDS];
    t_coef                    coef_all [NUM_COEFS];
    logic [CNT_WIDTH-1:0]     eff_taps;
    t_coef_vec                coef_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_REG_WIDTH'(1);
            for (int w = 0; w < COEF_WORDS; w++) begin
                r_coef_word[w] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TAP_COUNT:   r_tap_count    <= i_cfg_wdata[TAP_REG_WIDTH-1:0];
                REG_COEF_WORD_0: r_coef_word[0] <= i_cfg_wdata;
                REG_COEF_WORD_1: r_coef_word[1] <= i_cfg_wdata;
                REG_COEF_WORD_2: r_coef_word[2] <= i_cfg_wdata;
                REG_COEF_WORD_3: r_coef_word[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero means one tap, anything past the delay line length is clamped
    always_comb begin
        if (r_tap_count == '0) begin
            eff_taps = CNT_WIDTH'(1);
        end else if (32'(r_tap_count) > 32'(MAX_TAPS)) begin
            eff_taps = CNT_WIDTH'(MAX_TAPS);
        end else begin
            eff_taps = CNT_WIDTH'(r_tap_count);
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_COEFS; k++) begin
            coef_all[k] = r_coef_word[k / COEFS_PER_WORD]
                          [(k % COEFS_PER_WORD) * COEF_WIDTH +: COEF_WIDTH];
        end
    end

    // entry j of the delay line (newest first) meets tap eff_taps-1-j
    always_comb begin
        int kk;
        coef_sel = '0;
        for (int j = 0; j < MAX_TAPS; j++) begin
            kk = int'(eff_taps) - j - 1;
            if (kk >= 0 && kk < NUM_COEFS) begin
                coef_sel[j] = coef_all[kk[COEF_IDX_WIDTH-1:0]];
            end
        end
    end

    assign o_cfg_view = '{eff_taps: eff_taps, coef_sel: coef_sel};

endmodule

[design/vmfir_dline.sv]
// ----------------------------------------------------------------------------
// vmfir_dline
// input register stage: delay line, row fill count and output decision
// ----------------------------------------------------------------------------
module vmfir_dline (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  vmfir_pkg::t_sample     i_sample,
    input  logic                   i_row_start,
    input  logic                   i_s2_ready,
    input  vmfir_pkg::t_cfg_view   i_cfg_view,
    output vmfir_pkg::t_win_stage  o_win_stage
);
    import vmfir_pkg::*;

    logic [CNT_WIDTH-1:0] r_fill;
    logic [CNT_WIDTH-1:0] n_fill;
    logic [CNT_WIDTH-1:0] fill_base;
    t_window              r_dly;
    t_window              n_dly;
    logic                 r_s1_vld;
    logic                 s1_ready;
    logic                 accept;
    logic                 emit;

    assign s1_ready   = !r_s1_vld || i_s2_ready;
    assign o_in_stall = !s1_ready;
    assign accept     = i_in_valid && s1_ready;

    // row start restarts the count; stale entries are never weighted
    assign fill_base = i_row_start ? '0 : r_fill;
    assign n_fill    = (fill_base < CNT_WIDTH'(MAX_TAPS)) ? fill_base + CNT_WIDTH'(1)
                                                          : fill_base;
    assign emit      = n_fill >= i_cfg_view.eff_taps;

    always_comb begin
        n_dly[0] = i_sample;
        for (int k = 1; k < MAX_TAPS; k++) begin
            n_dly[k] = r_dly[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_vld <= accept && emit;
            end
            if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

    // unused entries meet a zero coefficient, so stale samples in them add nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly <= '0;
        end else if (accept) begin
            r_dly <= n_dly;
        end
    end

    assign o_win_stage = '{vld: r_s1_vld, win: r_dly};

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_WIDTH'(MAX_TAPS))
        else $error("fill count above delay line length");

    a_row_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept && i_row_start) |=> (r_fill == CNT_WIDTH'(1)))
        else $error("row start did not restart fill count");

    a_fill_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept && !i_row_start && r_fill < CNT_WIDTH'(MAX_TAPS))
        |=> (r_fill == $past(r_fill) + CNT_WIDTH'(1)))
        else $error("fill count did not advance");

    a_fill_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !accept) |=> $stable(r_fill))
        else $error("fill count moved without a word");

endmodule

[design/vmfir_mac.sv]
// ----------------------------------------------------------------------------
// vmfir_mac
// parallel tap products, grouped partial sums and the result register
// ----------------------------------------------------------------------------
module vmfir_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  vmfir_pkg::t_win_stage                 i_win_stage,
    input  vmfir_pkg::t_cfg_view                  i_cfg_view,
    output logic                                  o_s2_ready,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [vmfir_pkg::OUT_WIDTH-1:0] o_filter_out
);
    import vmfir_pkg::*;

    logic signed [PROD_WIDTH-1:0] r_prod [MAX_TAPS];
    logic signed [PROD_WIDTH-1:0] n_prod [MAX_TAPS];
    logic signed [PART_WIDTH-1:0] r_part [NUM_GROUPS];
    logic signed [PART_WIDTH-1:0] n_part [NUM_GROUPS];
    logic signed [OUT_WIDTH-1:0]  r_out;
    logic signed [OUT_WIDTH-1:0]  n_out;
    logic                         r_s2_vld;
    logic                         r_s3_vld;
    logic                         r_out_vld;
    logic                         s2_ready;
    logic                         s3_ready;
    logic                         out_ready;

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign s3_ready   = !r_s3_vld || out_ready;
    assign s2_ready   = !r_s2_vld || s3_ready;
    assign o_s2_ready = s2_ready;

    // unused taps carry a zero coefficient
    always_comb begin
        for (int j = 0; j < MAX_TAPS; j++) begin
            n_prod[j] = $signed(i_win_stage.win[j]) * $signed(i_cfg_view.coef_sel[j]);
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_part[g] = '0;
            for (int i = 0; i < GROUP_SIZE; i++) begin
                if (g * GROUP_SIZE + i < MAX_TAPS) begin
                    n_part[g] = n_part[g] + PART_WIDTH'(r_prod[g * GROUP_SIZE + i]);
                end
            end
        end
    end

    // sum of the group partial sums; it fits the output width, so it never wraps
    always_comb begin
        n_out = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_out = n_out + OUT_WIDTH'(r_part[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_vld <= i_win_stage.vld;
            end
            if (s3_ready) begin
                r_s3_vld <= r_s2_vld;
            end
            if (out_ready) begin
                r_out_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_win_stage.vld) begin
            r_prod <= n_prod;
        end
        if (s3_ready && r_s2_vld) begin
            r_part <= n_part;
        end
        if (out_ready && r_s3_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_filter_out = r_out;

endmodule

[design/valid_mode_fir_filter_top.sv]
// the sample that completes a window is registered in the delay line, then products, partial sums and the result word
// throughput: one sample per cycle while the output is not stalled; every stage is elastic, so bubbles collapse
// a stalled result holds only the stages behind it that are full
// reset (synchronous, active low): tap count 1, coefficients zero, row empty,
// all pipeline valids cleared
// ----------------------------------------------------------------------------
// valid_mode_fir_filter_top
// streaming valid-mode fir, one filter per row, exact 36-bit sum of products
// ----------------------------------------------------------------------------
module valid_mode_fir_filter_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [vmfir_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [vmfir_pkg::CFG_WIDTH-1:0]        i_cfg_wdata,
    // sample words in
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [vmfir_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic                                   i_row_start,
    // result words out
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [vmfir_pkg::OUT_WIDTH-1:0] o_filter_out
);
    import vmfir_pkg::*;

    t_cfg_view  cfg_view;     // clamped tap count and aligned coefficients
    t_win_stage win_stage;    // delay line snapshot plus emit flag
    logic       s2_ready;     // multiply stage can take the window

    // register file; the user must write it only while the pipeline is empty, the block does not enforce this
    vmfir_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg_view  (cfg_view)
    );

    // the delay line is the input register: it shifts on every accepted word,
    // and holds while a window waiting for the multiply stage is pending
    vmfir_dline u_dline (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .i_row_start (i_row_start),
        .i_s2_ready  (s2_ready),
        .i_cfg_view  (cfg_view),
        .o_win_stage (win_stage)
    );

    // products, partial sums of four taps, then the final sum into the result
    // register; the output stall reaches the input through a combinational ready chain
    vmfir_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_win_stage  (win_stage),
        .i_cfg_view   (cfg_view),
        .o_s2_ready   (s2_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_filter_out (o_filter_out)
    );

endmodule
